FILE: rtl/ctb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_pkg
// shared constants, codes and types of the countdown timer bank
// ----------------------------------------------------------------------------
package ctb_pkg;

   localparam int SLOTS       = 16;
   localparam int COUNT_WIDTH = 32;
   localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [SLOT_W-1:0] SLOT_FIRST = '0;
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOTS - 1);

   // request kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_YIELD = 2'd2;

   // result event codes
   localparam logic [2:0] EV_STARTED = 3'd0;
   localparam logic [2:0] EV_FULL    = 3'd1;
   localparam logic [2:0] EV_FIRED   = 3'd2;
   localparam logic [2:0] EV_TICK    = 3'd3;
   localparam logic [2:0] EV_YIELD   = 3'd4;

   // register index of slice_period
   localparam logic REG_SLICE_PERIOD = 1'b0;
   localparam logic [31:0] SLICE_PERIOD_RESET = 32'd10;

   // one slot entry as kept in the slot memory
   typedef struct packed {
      logic                   periodic;
      logic [COUNT_WIDTH-1:0] reload;
      logic [COUNT_WIDTH-1:0] remain;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // access from the sequencer to the slot memory
   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
   } mem_req_type;

   // slot index to the 4-bit result field (zero-extend or truncate)
   function automatic logic [3:0] to_slot_field(input logic [SLOT_W-1:0] idx);
      logic [SLOT_W+3:0] wide;
      wide = {4'b0000, idx};
      return wide[3:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/ctb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module ctb_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/ctb_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_csr
// register port holding the time slice period
// ----------------------------------------------------------------------------
module ctb_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [ctb_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready,
   output logic      [31:0]                    slice_period
);
   import ctb_pkg::*;

   logic [31:0] slice_period_ff;
   logic [31:0] slice_period_in;
   logic        reg_index;
   logic        wr_hit;

   assign reg_index = paddr[2];
   assign pready    = 1'b1;
   assign wr_hit    = psel && penable && pwrite && (reg_index == REG_SLICE_PERIOD);

   assign slice_period_in = wr_hit ? pwdata : slice_period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slice_period_ff <= SLICE_PERIOD_RESET;
      end else begin
         slice_period_ff <= slice_period_in;
      end
   end

   assign prdata       = (reg_index == REG_SLICE_PERIOD) ? slice_period_ff : 32'd0;
   assign slice_period = slice_period_ff;

endmodule
`default_nettype wire

FILE: rtl/ctb_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctb_engine
// request sequencer: slot walk over the slot memory, slice counter, result register
// ----------------------------------------------------------------------------
module ctb_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [1:0]           req_kind,
   input  wire logic [31:0]          req_reload_ticks,
   input  wire logic                 req_periodic,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [2:0]           rsp_event_res,
   output logic      [3:0]           rsp_slot,
   output logic                      rsp_schedule_now,
   output logic                      rsp_last,
   input  wire logic [31:0]          slice_period,
   output ctb_pkg::mem_req_type      mem_req,
   input  wire ctb_pkg::entry_type   mem_rd_data
);
   import ctb_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE      = 6'b000001,
      S_START     = 6'b000010,
      S_YIELD     = 6'b000100,
      S_TICK_RD   = 6'b001000,
      S_TICK_RUN  = 6'b010000,
      S_TICK_DONE = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic [SLOTS-1:0]       in_use_ff, in_use_in;
   logic [31:0]            slice_count_ff, slice_count_in;
   logic [COUNT_WIDTH-1:0] load_ff, load_in;
   logic                   periodic_ff, periodic_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             event_ff, event_in;
   logic [3:0]             slot_ff, slot_in;
   logic                   sched_ff, sched_in;
   logic                   last_ff, last_in;

   logic                   accept;
   logic                   out_free;
   logic                   emit;
   logic                   stall;
   logic                   live;
   logic                   fire;
   logic [COUNT_WIDTH-1:0] dec;
   logic                   any_free;
   logic [SLOT_W-1:0]      free_idx;
   logic [31:0]            slice_inc;
   logic                   slice_hit;
   logic [COUNT_WIDTH+31:0] load_wide;

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign load_wide = {{COUNT_WIDTH{1'b0}}, req_reload_ticks};

   // lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = SLOT_FIRST;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            any_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   assign live  = in_use_ff[idx_ff];
   assign dec   = mem_rd_data.remain - COUNT_WIDTH'(1);
   assign fire  = live && (dec == '0);
   assign stall = fire && !out_free;

   assign slice_inc = (slice_count_ff == 32'hFFFF_FFFF) ? slice_count_ff
                                                        : slice_count_ff + 32'd1;
   assign slice_hit = (slice_inc >= slice_period);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      in_use_in      = in_use_ff;
      slice_count_in = slice_count_ff;
      load_in        = load_ff;
      periodic_in    = periodic_ff;
      emit           = 1'b0;
      event_in       = event_ff;
      slot_in        = slot_ff;
      sched_in       = 1'b0;
      last_in        = 1'b0;
      mem_req        = '0;
      mem_req.wr_addr = idx_ff;
      mem_req.wr_data = mem_rd_data;
      mem_req.rd_addr = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               load_in     = load_wide[COUNT_WIDTH-1:0];
               periodic_in = req_periodic;
               idx_in      = SLOT_FIRST;
               unique case (req_kind)
                  KIND_TICK:  state_in = S_TICK_RD;
                  KIND_START: state_in = S_START;
                  KIND_YIELD: state_in = S_YIELD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_START: begin
            if (out_free) begin
               emit     = 1'b1;
               last_in  = 1'b1;
               state_in = S_IDLE;
               if (any_free) begin
                  mem_req.wr_en            = 1'b1;
                  mem_req.wr_addr          = free_idx;
                  mem_req.wr_data.periodic = periodic_ff;
                  mem_req.wr_data.reload   = load_ff;
                  mem_req.wr_data.remain   = load_ff;
                  in_use_in[free_idx]      = 1'b1;
                  event_in                 = EV_STARTED;
                  slot_in                  = to_slot_field(free_idx);
               end else begin
                  event_in = EV_FULL;
                  slot_in  = 4'd0;
               end
            end
         end
         S_YIELD: begin
            if (out_free) begin
               emit           = 1'b1;
               last_in        = 1'b1;
               event_in       = EV_YIELD;
               slot_in        = 4'd0;
               slice_count_in = slice_period;
               state_in       = S_IDLE;
            end
         end
         S_TICK_RD: begin
            mem_req.rd_en = 1'b1;
            state_in      = S_TICK_RUN;
         end
         S_TICK_RUN: begin
            if (!stall) begin
               if (live) begin
                  mem_req.wr_en = 1'b1;
                  mem_req.wr_data.remain = (fire && mem_rd_data.periodic)
                                           ? mem_rd_data.reload : dec;
                  if (fire && !mem_rd_data.periodic) begin
                     in_use_in[idx_ff] = 1'b0;
                  end
               end
               if (fire) begin
                  emit     = 1'b1;
                  event_in = EV_FIRED;
                  slot_in  = to_slot_field(idx_ff);
               end
               if (idx_ff == SLOT_LAST) begin
                  state_in = S_TICK_DONE;
               end else begin
                  idx_in          = idx_ff + SLOT_W'(1);
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = idx_ff + SLOT_W'(1);
               end
            end
         end
         S_TICK_DONE: begin
            if (out_free) begin
               emit           = 1'b1;
               last_in        = 1'b1;
               event_in       = EV_TICK;
               slot_in        = 4'd0;
               sched_in       = slice_hit;
               slice_count_in = slice_hit ? 32'd0 : slice_inc;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         in_use_ff      <= '0;
         slice_count_ff <= 32'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         in_use_ff      <= in_use_in;
         slice_count_ff <= slice_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      load_ff     <= load_in;
      periodic_ff <= periodic_in;
      if (emit) begin
         event_ff <= event_in;
         slot_ff  <= slot_in;
         sched_ff <= sched_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = event_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_schedule_now = sched_ff;
   assign rsp_last         = last_ff;

`ifndef SYNTHESIS
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en && mem_req.rd_en) |-> (mem_req.wr_addr != mem_req.rd_addr))
      else $error("slot memory read and write hit the same entry");

   a_walk_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK_RUN && !stall && idx_ff != SLOT_LAST)
      |=> (idx_ff == $past(idx_ff) + SLOT_W'(1)))
      else $error("slot walk skipped or repeated a slot");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result loaded over an untaken result");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((event_ff == EV_FIRED) == !last_ff))
      else $error("last flag does not match result kind");

   a_slice_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TICK_DONE && out_free && slice_hit) |=> (slice_count_ff == 32'd0))
      else $error("slice counter not cleared after schedule request");
`endif

endmodule
`default_nettype wire

FILE: rtl/countdown_timer_bank.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// countdown_timer_bank
// bank of countdown timer slots with a scheduler time slice counter
// ----------------------------------------------------------------------------
//
//  channel  | ports                      | carries
//  ---------+----------------------------+---------------------------------
//  req      | req_valid / req_ready      | kind, reload_ticks, periodic
//  rsp      | rsp_valid / rsp_ready      | event_res, slot, schedule_now, last
//  csr      | csr_psel .. csr_pready     | slice_period at byte address 0
//
//  a start or a yield moves from idle to its own state, which loads the result once the
//  result register is free; a tick passes the read-ahead state, then the walk state with
//    one slot memory read per cycle in slot order while the walk does not stall, then the
//    closing tick result; the sequencer then returns to idle for the next request
//  a request is accepted only while the sequencer is idle
//  a full result register stalls the walk at the next slot that fires
//  reset clears the slot valid bits and the slice counter;
//    memory contents are rewritten on every start, so no clearing pass
//
// ----------------------------------------------------------------------------
module countdown_timer_bank (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // requests
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_kind,
   input  wire logic [31:0]                    req_reload_ticks,
   input  wire logic                           req_periodic,
   // results
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [2:0]                     rsp_event_res,
   output logic      [3:0]                     rsp_slot,
   output logic                                rsp_schedule_now,
   output logic                                rsp_last,
   // register port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [ctb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                    csr_pwdata,
   output logic      [31:0]                    csr_prdata,
   output logic                                csr_pready
);
   import ctb_pkg::*;

   // time slice period from the register block
   logic [31:0]  slice_period;

   // sequencer access to the slot memory
   mem_req_type  mem_req;
   entry_type    mem_rd_data;
   logic [ENTRY_W-1:0] mem_rd_raw;

   ctb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (csr_psel),
      .penable      (csr_penable),
      .pwrite       (csr_pwrite),
      .paddr        (csr_paddr),
      .pwdata       (csr_pwdata),
      .prdata       (csr_prdata),
      .pready       (csr_pready),
      .slice_period (slice_period)
   );

   // slot store: remaining count, reload value and mode of every slot;
   // the live bit of each slot sits in flip-flops inside the sequencer
   ctb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_raw)
   );

   assign mem_rd_data = entry_type'(mem_rd_raw);

   // walk writes back slot i while reading slot i+1, so no forwarding needed
   ctb_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_reload_ticks (req_reload_ticks),
      .req_periodic     (req_periodic),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_slot         (rsp_slot),
      .rsp_schedule_now (rsp_schedule_now),
      .rsp_last         (rsp_last),
      .slice_period     (slice_period),
      .mem_req          (mem_req),
      .mem_rd_data      (mem_rd_data)
   );

endmodule
`default_nettype wire
